[rtl/core/pcprb_pkg.sv]
`default_nettype none
package pcprb_pkg;

   // coordinate width of point_x / point_y
   localparam int COORD_BITS = 16;

   localparam int NUM_BINS    = 361;
   localparam int CENTER_BIN  = 180;
   localparam int TOP_BIN     = 360;
   localparam int TRIG_N      = 91;
   localparam int SRCH_ITERS  = 7;
   localparam logic [15:0] EMPTY_VAL = 16'hFFFF;
   localparam logic [15:0] MAX_DIST  = 16'hFFFE;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_POINT = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE31  = 64'h0000_0000_8000_0000;
   localparam logic [63:0] HALF31 = 64'h0000_0000_4000_0000;

   typedef logic [TRIG_N-1:0][31:0] trig_tab_type;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic [8:0]                   bin_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [8:0]  bin_written;
      logic [15:0] distance;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic root_step;
      logic srch_mul;
      logic srch_cmp;
      logic wr_lo;
      logic wr_hi;
      logic rd;
      logic sweep;
   } dp_ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       keep;
      logic       top_bin;
      logic       sweep_last;
   } dp_sts_type;

   // sin/cos of whole degrees at scale 2^31, one-degree rotation steps,
   // mirrored about 45 degrees
   function automatic trig_tab_type build_trig(input logic want_sin);
      logic [63:0]  t, t2, t3, t4, t5, s1, c1, s, c;
      trig_tab_type st, ct;
      st = '0;
      ct = '0;
      t  = (PI_Q60 >> 29) / 64'd180;
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t2 * t2) >> 31;
      t5 = (t4 * t) >> 31;
      s1 = t - t3 / 64'd6 + t5 / 64'd120;
      c1 = ONE31 - t2 / 64'd2 + t4 / 64'd24;
      st[0] = 32'd0;
      ct[0] = ONE31[31:0];
      for (int k = 1; k <= 45; k++) begin
         s = {32'd0, st[k-1]};
         c = {32'd0, ct[k-1]};
         st[k] = 32'((s * c1 + c * s1 + HALF31) >> 31);
         ct[k] = 32'((c * c1 - s * s1 + HALF31) >> 31);
      end
      st[45] = ct[45];
      for (int k = 46; k <= 90; k++) begin
         st[k] = ct[90-k];
         ct[k] = st[90-k];
      end
      return want_sin ? st : ct;
   endfunction

   localparam trig_tab_type SIN_TAB = build_trig(1'b1);
   localparam trig_tab_type COS_TAB = build_trig(1'b0);

endpackage
`default_nettype wire

[rtl/core/pcprb_datapath.sv]
`default_nettype none
module pcprb_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire pcprb_pkg::dp_ctl_type ctl,
   input  wire pcprb_pkg::req_type    req_item,
   input  wire                        csr_wr,
   input  wire  [15:0]                csr_data,
   output pcprb_pkg::dp_sts_type      sts,
   output pcprb_pkg::rsp_type         rsp_item
);
   localparam int CB = pcprb_pkg::COORD_BITS;
   localparam int RW = 2 * CB + 32;

   logic [1:0]    cmd_ff;
   logic [CB-1:0] x_ff, y_ff;
   logic [8:0]    idx_ff;
   logic [15:0]   min_radius_ff;

   logic [2*CB-1:0] sqx_ff, sqy_ff, d2_ff, d2sh_ff;
   logic [31:0]     radsq_ff;
   logic [CB+1:0]   rem_ff;
   logic [CB-1:0]   root_ff;
   logic [6:0]      lo_ff, hi_ff, mid_ff;
   logic [CB+31:0]  pc_ff, ps_ff;
   logic [8:0]      sweep_ff;
   logic            top_written_ff;
   logic [15:0]     rdata_ff;
   logic [15:0]     mem [0:pcprb_pkg::NUM_BINS-1];

   logic          xneg, yneg;
   logic [CB-1:0] ax, ay;
   logic [CB+3:0] nxt, trial;
   logic [7:0]    mid_sum;
   logic [6:0]    mid;
   logic [8:0]    bin, raddr, waddr;
   logic [15:0]   dist_val, wdata;
   logic [CB+15:0] root_x;
   logic          keep, we;

   assign xneg = x_ff[CB-1];
   assign yneg = y_ff[CB-1];
   assign ax   = xneg ? (~x_ff + 1'b1) : x_ff;
   assign ay   = yneg ? (~y_ff + 1'b1) : y_ff;

   assign nxt   = {rem_ff, d2sh_ff[2*CB-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 8'd1;
   assign mid     = mid_sum[7:1];

   assign bin = yneg ? (9'(pcprb_pkg::CENTER_BIN) - {1'b0, lo_ff, 1'b0})
                     : (9'(pcprb_pkg::CENTER_BIN) + {1'b0, lo_ff, 1'b0});

   assign root_x   = (CB+16)'(root_ff);
   assign dist_val = (root_x > (CB+16)'(pcprb_pkg::MAX_DIST)) ? pcprb_pkg::MAX_DIST
                                                             : root_x[15:0];
   assign keep     = !xneg && (RW'(d2_ff) > RW'(radsq_ff));

   assign sts.cmd        = cmd_ff;
   assign sts.keep       = keep;
   assign sts.top_bin    = (bin == 9'(pcprb_pkg::TOP_BIN));
   assign sts.sweep_last = (sweep_ff == 9'(pcprb_pkg::TOP_BIN));

   // bin 360 never written since clear mirrors bin 359
   assign raddr = (idx_ff == 9'(pcprb_pkg::TOP_BIN) && !top_written_ff)
                  ? 9'(pcprb_pkg::TOP_BIN - 1) : idx_ff;

   always_comb begin
      we    = ctl.sweep || ctl.wr_lo || ctl.wr_hi;
      waddr = bin;
      wdata = dist_val;
      priority if (ctl.sweep) begin
         waddr = sweep_ff;
         wdata = pcprb_pkg::EMPTY_VAL;
      end else if (ctl.wr_hi) begin
         waddr = bin + 9'd1;
      end else begin
         waddr = bin;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff  <= '0;
         sweep_ff       <= '0;
         top_written_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            min_radius_ff <= csr_data;
         end
         if (ctl.load) begin
            sweep_ff <= '0;
         end else if (ctl.sweep) begin
            sweep_ff <= sweep_ff + 9'd1;
         end
         if (ctl.sweep) begin
            top_written_ff <= 1'b0;
         end else if (ctl.wr_lo && sts.top_bin) begin
            top_written_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_item.command;
         x_ff   <= req_item.point_x;
         y_ff   <= req_item.point_y;
         idx_ff <= req_item.bin_index;
         lo_ff  <= 7'd0;
         hi_ff  <= 7'(pcprb_pkg::TRIG_N - 1);
      end
      if (ctl.square) begin
         sqx_ff   <= ax * ax;
         sqy_ff   <= ay * ay;
         radsq_ff <= min_radius_ff * min_radius_ff;
      end
      if (ctl.sum) begin
         d2_ff   <= sqx_ff + sqy_ff;
         d2sh_ff <= sqx_ff + sqy_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (ctl.root_step) begin
         d2sh_ff <= {d2sh_ff[2*CB-3:0], 2'b00};
         if (nxt >= trial) begin
            rem_ff  <= (CB+2)'(nxt - trial);
            root_ff <= {root_ff[CB-2:0], 1'b1};
         end else begin
            rem_ff  <= nxt[CB+1:0];
            root_ff <= {root_ff[CB-2:0], 1'b0};
         end
      end
      if (ctl.srch_mul) begin
         pc_ff  <= ay * pcprb_pkg::COS_TAB[mid];
         ps_ff  <= ax * pcprb_pkg::SIN_TAB[mid];
         mid_ff <= mid;
      end
      if (ctl.srch_cmp && lo_ff < hi_ff) begin
         if (pc_ff >= ps_ff) begin
            lo_ff <= mid_ff;
         end else begin
            hi_ff <= mid_ff - 7'd1;
         end
      end
   end

   always_comb begin
      rsp_item.accepted    = 1'b0;
      rsp_item.bin_written = 9'd0;
      rsp_item.distance    = pcprb_pkg::EMPTY_VAL;
      unique case (cmd_ff)
         pcprb_pkg::CMD_POINT: begin
            rsp_item.accepted    = keep;
            rsp_item.bin_written = keep ? bin : 9'd0;
            rsp_item.distance    = dist_val;
         end
         pcprb_pkg::CMD_READ: begin
            rsp_item.distance = (idx_ff > 9'(pcprb_pkg::TOP_BIN))
                                ? pcprb_pkg::EMPTY_VAL : rdata_ff;
         end
         default: begin
            rsp_item.distance = pcprb_pkg::EMPTY_VAL;
         end
      endcase
   end
endmodule
`default_nettype wire

[rtl/core/pcprb_ctrl.sv]
`default_nettype none
module pcprb_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire pcprb_pkg::dp_sts_type sts,
   output pcprb_pkg::dp_ctl_type      ctl,
   output logic                       busy,
   output logic                       rsp_valid
);
   localparam int CB = pcprb_pkg::COORD_BITS;
   localparam int CW = $clog2(CB);

   typedef enum logic [11:0] {
      ST_SWEEP = 12'b0000_0000_0001,
      ST_IDLE  = 12'b0000_0000_0010,
      ST_DISP  = 12'b0000_0000_0100,
      ST_SQ    = 12'b0000_0000_1000,
      ST_SUM   = 12'b0000_0001_0000,
      ST_ROOT  = 12'b0000_0010_0000,
      ST_SMUL  = 12'b0000_0100_0000,
      ST_SCMP  = 12'b0000_1000_0000,
      ST_WLO   = 12'b0001_0000_0000,
      ST_WHI   = 12'b0010_0000_0000,
      ST_RD    = 12'b0100_0000_0000,
      ST_RSP   = 12'b1000_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           pend_ff, pend_in;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = pend_ff ? ST_RSP : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            unique case (sts.cmd)
               pcprb_pkg::CMD_CLEAR: begin
                  state_in = ST_SWEEP;
                  pend_in  = 1'b1;
               end
               pcprb_pkg::CMD_POINT: state_in = ST_SQ;
               pcprb_pkg::CMD_READ:  state_in = ST_RD;
               default:              state_in = ST_RSP;
            endcase
         end
         ST_SQ: begin
            ctl.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            ctl.sum  = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            ctl.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CB - 1)) begin
               cnt_in   = '0;
               state_in = ST_SMUL;
            end
         end
         ST_SMUL: begin
            ctl.srch_mul = 1'b1;
            state_in     = ST_SCMP;
         end
         ST_SCMP: begin
            ctl.srch_cmp = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            state_in     = ST_SMUL;
            if (cnt_ff == CW'(pcprb_pkg::SRCH_ITERS - 1)) begin
               cnt_in   = '0;
               state_in = ST_WLO;
            end
         end
         ST_WLO: begin
            ctl.wr_lo = sts.keep;
            state_in  = (sts.keep && !sts.top_bin) ? ST_WHI : ST_RSP;
         end
         ST_WHI: begin
            ctl.wr_hi = 1'b1;
            state_in  = ST_RSP;
         end
         ST_RD: begin
            ctl.rd   = 1'b1;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end
endmodule
`default_nettype wire

[rtl/core/point_cloud_polar_range_binning.sv]
`default_nettype none
// Channel   Ports                          Direction  Handshake
// request   start, busy, req_item          in         taken when start & !busy
// response  rsp_valid, rsp_item            out        one-cycle strobe, no stall
// csr       csr_valid, csr_ready, csr_data in         written when valid & ready
//
// Point item, from start to strobe: squares, sum, one root bit per cycle,
//   then a 7-step binary search over the degree table with a registered
//   multiply pair per step, then writes; the second write is skipped when
//   at most one bin is written.
// Read item: one registered memory read. Clear item: a pass over all 361 bins.
// After reset a clearing pass empties the 361 bins while busy is high.
// The response side cannot stall; busy falls the cycle after the strobe.
module point_cloud_polar_range_binning (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire pcprb_pkg::req_type req_item,
   output logic                    rsp_valid,
   output pcprb_pkg::rsp_type      rsp_item,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [15:0]             csr_data
);
   pcprb_pkg::dp_ctl_type ctl;
   pcprb_pkg::dp_sts_type sts;

   // user changes min_radius only between items; the block does not enforce it
   assign csr_ready = 1'b1;

   pcprb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pcprb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_item (req_item),
      .csr_wr   (csr_valid & csr_ready),
      .csr_data (csr_data),
      .sts      (sts),
      .rsp_item (rsp_item)
   );
endmodule
`default_nettype wire

[sim/point_cloud_polar_range_binning_checker.sv]
`timescale 1ns / 100ps
module point_cloud_polar_range_binning_checker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 busy,
   input  pcprb_pkg::req_type  req_item,
   input  wire                 rsp_valid,
   input  pcprb_pkg::rsp_type  rsp_item,
   input  wire                 csr_valid,
   input  wire                 csr_ready,
   input  wire  [15:0]         csr_data,
   output int                  fail_count,
   output int                  pending
);
   import pcprb_pkg::*;

   logic [63:0]       sin_deg [0:90];
   logic [63:0]       cos_deg [0:90];
   logic [15:0]       bin_store [0:360];
   logic              top_written;
   logic [15:0]       min_radius;
   rsp_type           binning_q [$];

   // whole-degree sin/cos at 2^31: series for one degree, then rotation
   initial begin
      logic [63:0] t, t2, t3, t4, t5, s1, c1;
      t  = (64'h3243F6A8885A308D >> 29) / 64'd180;
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t2 * t2) >> 31;
      t5 = (t4 * t) >> 31;
      s1 = t - t3 / 64'd6 + t5 / 64'd120;
      c1 = 64'h8000_0000 - t2 / 64'd2 + t4 / 64'd24;
      sin_deg[0] = 64'd0;
      cos_deg[0] = 64'h8000_0000;
      for (int k = 1; k <= 45; k++) begin
         sin_deg[k] = (sin_deg[k-1] * c1 + cos_deg[k-1] * s1 + 64'h4000_0000) >> 31;
         cos_deg[k] = (cos_deg[k-1] * c1 - sin_deg[k-1] * s1 + 64'h4000_0000) >> 31;
      end
      sin_deg[45] = cos_deg[45];
      for (int k = 46; k <= 90; k++) begin
         sin_deg[k] = cos_deg[90-k];
         cos_deg[k] = sin_deg[90-k];
      end
   end

   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // works out the result of one item and updates the bin store
   function automatic rsp_type bin_point(input req_type rq);
      rsp_type     res;
      logic [63:0] ax, ay, d2, d;
      int          cnt, bin;
      res = '{accepted: 1'b0, bin_written: 9'd0, distance: EMPTY_VAL};
      case (rq.command)
         CMD_CLEAR: begin
            for (int i = 0; i < NUM_BINS; i++) bin_store[i] = EMPTY_VAL;
            top_written = 1'b0;
         end
         CMD_POINT: begin
            ax = rq.point_x[15] ? 64'(-longint'(rq.point_x)) : 64'(rq.point_x);
            ay = rq.point_y[15] ? 64'(-longint'(rq.point_y)) : 64'(rq.point_y);
            d2 = ax * ax + ay * ay;
            d  = floor_root(d2);
            if (d > 64'(MAX_DIST)) d = 64'(MAX_DIST);
            res.distance = d[15:0];
            if (!rq.point_x[15] && d2 > 64'(min_radius) * 64'(min_radius)) begin
               cnt = 0;
               for (int j = 1; j <= 90; j++)
                  if (ay * cos_deg[j] >= ax * sin_deg[j]) cnt++;
               bin = rq.point_y[15] ? CENTER_BIN - 2 * cnt : CENTER_BIN + 2 * cnt;
               if (bin < TOP_BIN) begin
                  bin_store[bin]   = d[15:0];
                  bin_store[bin+1] = d[15:0];
               end else begin
                  bin_store[TOP_BIN] = d[15:0];
                  top_written = 1'b1;
               end
               res.accepted    = 1'b1;
               res.bin_written = 9'(bin);
            end
         end
         CMD_READ: begin
            if (rq.bin_index > 9'(TOP_BIN))
               res.distance = EMPTY_VAL;
            else if (rq.bin_index == 9'(TOP_BIN) && !top_written)
               res.distance = bin_store[TOP_BIN-1];
            else
               res.distance = bin_store[rq.bin_index];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) bin_store[i] = EMPTY_VAL;
         top_written = 1'b0;
         min_radius  = 16'd0;
         binning_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (rsp_valid) begin
            if (binning_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result %p at %0t", rsp_item, $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = binning_q.pop_front();
               if (want.accepted != rsp_item.accepted
                   || want.bin_written != rsp_item.bin_written
                   || want.distance != rsp_item.distance) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %p, got %p at %0t",
                              want, rsp_item, $realtime);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) min_radius = csr_data;
         if (start && !busy) binning_q.push_back(bin_point(req_item));
         pending <= binning_q.size();
      end
   end
endmodule

[sim/tb_point_cloud_polar_range_binning.sv]
`timescale 1ns / 100ps
module tb_point_cloud_polar_range_binning;
   import pcprb_pkg::*;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   req_type   req_item = '0;
   logic      rsp_valid;
   rsp_type   rsp_item;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   logic [15:0] csr_data = '0;
   int        fail_count;
   int        pending;
   logic      quiet = 1'b0;

   always #6 clock = ~clock;

   point_cloud_polar_range_binning dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   point_cloud_polar_range_binning_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // hard stop: worst case is well under this even with clears mixed in
   initial begin
      #25ms;
      $display("Mismatches found");
      $finish;
   end

   // hold start and the item until busy is seen low ahead of an edge;
   // start stays high into the next item unless the sender idles
   task automatic issue(input logic [1:0] cmd, input logic [15:0] x,
                        input logic [15:0] y, input logic [8:0] idx);
      logic taken;
      if (!quiet && $urandom_range(99) < 32) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_item = '{command: cmd, point_x: x, point_y: y, bin_index: idx};
      start = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         taken = !busy;
         @(negedge clock);
      end
   endtask

   // block idle: every result back and busy low
   task automatic drain();
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   task automatic set_radius(input logic [15:0] r);
      logic taken;
      drain();
      csr_data  = r;
      csr_valid = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         taken = csr_ready;
         @(negedge clock);
      end
      csr_valid = 1'b0;
   endtask

   task automatic random_point();
      logic [15:0] x, y;
      case ($urandom_range(9))
         0, 1, 2: begin
            x = 16'($urandom);
            y = 16'($urandom);
         end
         3, 4, 5: begin
            x = 16'($urandom_range(32767));
            y = 16'($urandom);
         end
         6: begin
            x = 16'($urandom_range(100));
            y = 16'($signed($urandom_range(200)) - 100);
         end
         7: begin
            x = 16'd0;
            y = 16'($urandom);
         end
         8: begin
            x = 16'($urandom);
            y = 16'd0;
         end
         default: begin
            // near 45 degrees, either side
            x = 16'($urandom_range(30000));
            y = x + 16'($urandom_range(2)) - 16'd1;
            if ($urandom_range(1)) y = -y;
         end
      endcase
      issue(CMD_POINT, x, y, 9'($urandom));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)      random_point();
      else if (pick < 85) issue(CMD_READ, 16'($urandom), 16'($urandom),
                                9'($urandom_range(360)));
      else if (pick < 93) issue(CMD_READ, 16'($urandom), 16'($urandom), 9'($urandom));
      else if (pick < 97) issue(CMD_CLEAR, 16'($urandom), 16'($urandom), 9'($urandom));
      else                issue(2'd3, 16'($urandom), 16'($urandom), 9'($urandom));
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: unwritten top bin, extremes, axes and 45 degrees
      issue(CMD_READ, 16'd0, 16'd0, 9'd360);
      issue(CMD_READ, 16'd0, 16'd0, 9'd0);
      issue(CMD_POINT, 16'd0, 16'd0, 9'd0);          // origin
      issue(CMD_POINT, 16'h8000, 16'd5, 9'd0);       // negative x
      issue(CMD_POINT, 16'h7FFF, 16'd0, 9'd0);       // straight ahead
      issue(CMD_POINT, 16'd100, 16'd100, 9'd0);
      issue(CMD_POINT, 16'd100, -16'sd100, 9'd0);
      issue(CMD_POINT, 16'd0, -16'sd300, 9'd0);      // hard right, bins 0 and 1
      issue(CMD_READ, 16'd0, 16'd0, 9'd359);
      issue(CMD_READ, 16'd0, 16'd0, 9'd360);         // still mirrors bin 359
      issue(CMD_POINT, 16'd0, 16'h7FFF, 9'd0);       // hard left, bin 360 only
      issue(CMD_READ, 16'd0, 16'd0, 9'd360);
      issue(CMD_READ, 16'd0, 16'd0, 9'd359);
      issue(CMD_POINT, 16'h8000, 16'h8000, 9'd0);
      issue(CMD_POINT, 16'h7FFF, 16'h8000, 9'd0);
      issue(CMD_READ, 16'd0, 16'd0, 9'd361);         // past the last bin
      issue(CMD_READ, 16'hFFFF, 16'hFFFF, 9'h1FF);
      issue(2'd3, 16'd1, 16'd1, 9'd1);
      issue(CMD_CLEAR, 16'd0, 16'd0, 9'd0);
      issue(CMD_READ, 16'd0, 16'd0, 9'd360);

      // radius boundary: 3,4 sits on it, 3,5 lies just outside
      set_radius(16'd5);
      issue(CMD_POINT, 16'd3, 16'd4, 9'd0);
      issue(CMD_POINT, 16'd3, 16'd5, 9'd0);
      issue(CMD_READ, 16'd0, 16'd0, 9'd180);

      // largest radius drops every point
      set_radius(16'hFFFF);
      for (int i = 0; i < 150; i++) random_item();

      set_radius(16'd0);
      for (int i = 0; i < 400; i++) begin
         quiet = (i >= 100 && i < 300);
         random_item();
         if (i == 200) drain();       // sender waits for every result
      end
      quiet = 1'b0;

      set_radius(16'($urandom_range(4000)));
      for (int i = 0; i < 450; i++) random_item();

      set_radius(16'($urandom));
      for (int i = 0; i < 150; i++) random_item();

      set_radius(16'd100);
      for (int i = 0; i < 250; i++) random_item();

      drain();
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
